// ===== rtl/mafs_pkg.sv =====
// ----------------------------------------------------------------------------
// mafs_pkg: MPEG audio frame splitter package
// Types, codes and header decode tables used by the splitter module.
// ----------------------------------------------------------------------------
package mafs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KbpsW = 9;
  localparam int unsigned HzW   = 16;
  localparam int unsigned LenW  = 12;
  localparam int unsigned NumW  = 26;  // 144 * 448 * 1000 fits in 26 bits
  localparam int unsigned FactW = 18;

  localparam logic [FactW-1:0] FACTOR_L1  = 18'd12000;   // 12 * 1000
  localparam logic [FactW-1:0] FACTOR_L23 = 18'd144000;  // 144 * 1000
  localparam logic [LenW-1:0]  HDR_BYTES  = 12'd4;

  localparam logic [1:0] VER_NONE   = 2'd0;
  localparam logic [1:0] VER_MPEG1  = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG25 = 2'd3;

  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_1    = 2'd1;
  localparam logic [1:0] LAYER_2    = 2'd2;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_MUL,
    ST_DIV,
    ST_LEN,
    ST_PAYLOAD
  } state_e;

  typedef enum logic [1:0] {
    STATUS_SKIP    = 2'd0,
    STATUS_HEADER  = 2'd1,
    STATUS_PAYLOAD = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    status_e          status;
    logic [1:0]       version_code;
    logic [1:0]       layer_number;
    logic             protection_bit;
    logic [KbpsW-1:0] bitrate_kbps;
    logic [HzW-1:0]   sample_rate_hz;
    logic             padding_bit;
    logic [1:0]       channel_mode;
    logic [LenW-1:0]  frame_bytes;
    logic             last_of_frame;
  } result_t;

  // bitrate tables, entry 15 is the forbidden index
  localparam logic [KbpsW-1:0] KBPS_V1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  localparam logic [HzW-1:0] RATE_V1 [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
  localparam logic [HzW-1:0] RATE_V25 [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

  function automatic logic [1:0] decode_version(input logic [1:0] code);
    logic [1:0] ver;
    case (code)
      2'd3:    ver = VER_MPEG1;
      2'd2:    ver = VER_MPEG2;
      2'd0:    ver = VER_MPEG25;
      default: ver = VER_NONE;
    endcase
    return ver;
  endfunction

  // 3 -> 1, 2 -> 2, 1 -> 3, 0 -> none
  function automatic logic [1:0] decode_layer(input logic [1:0] code);
    return 2'd0 - code;
  endfunction

  function automatic logic [KbpsW-1:0] decode_kbps(input logic [1:0] ver,
                                                   input logic [1:0] lay,
                                                   input logic [3:0] idx);
    logic [KbpsW-1:0] kbps;
    if (ver == VER_NONE || lay == LAYER_NONE) begin
      kbps = '0;
    end else if (ver == VER_MPEG1) begin
      if (lay == LAYER_1) begin
        kbps = KBPS_V1_L1[idx];
      end else if (lay == LAYER_2) begin
        kbps = KBPS_V1_L2[idx];
      end else begin
        kbps = KBPS_V1_L3[idx];
      end
    end else if (lay == LAYER_1) begin
      kbps = KBPS_V2_L1[idx];
    end else begin
      kbps = KBPS_V2_L23[idx];
    end
    return kbps;
  endfunction

  function automatic logic [HzW-1:0] decode_rate(input logic [1:0] ver,
                                                 input logic [1:0] idx);
    logic [HzW-1:0] hz;
    case (ver)
      VER_MPEG1:  hz = RATE_V1[idx];
      VER_MPEG2:  hz = {RATE_V25[idx][HzW-2:0], 1'b0};
      VER_MPEG25: hz = RATE_V25[idx];
      default:    hz = '0;
    endcase
    return hz;
  endfunction

endpackage

// ===== rtl/mafs_if.sv =====
// ----------------------------------------------------------------------------
// mafs_if: splitter channel interfaces
// Valid/ready channels for the byte stream in and the result items out.
// ----------------------------------------------------------------------------
interface mafs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mafs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [1:0]  version_code;
  logic [1:0]  layer_number;
  logic        protection_bit;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic        padding_bit;
  logic [1:0]  channel_mode;
  logic [11:0] frame_bytes;
  logic        last_of_frame;

  modport source (
    output valid, input ready,
    output out_byte, output status, output version_code, output layer_number,
    output protection_bit, output bitrate_kbps, output sample_rate_hz,
    output padding_bit, output channel_mode, output frame_bytes, output last_of_frame
  );
  modport sink (
    input valid, output ready,
    input out_byte, input status, input version_code, input layer_number,
    input protection_bit, input bitrate_kbps, input sample_rate_hz,
    input padding_bit, input channel_mode, input frame_bytes, input last_of_frame
  );
endinterface

// ===== rtl/mpeg_audio_frame_splitter.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_frame_splitter: MPEG audio frame header sync and splitter
// Hunts for a valid frame header in a byte stream, reports the decoded
// header with the frame length, then passes the frame payload through.
// ----------------------------------------------------------------------------
//   channel | dir | handshake     | item
//   in_i    | in  | valid / ready | one stream byte (data_byte)
//   out_o   | out | valid / ready | one result per byte: byte, status, header
//
// A skipped or payload byte is accepted whenever the output register is free.
// A header's last byte starts a multiply step for kbps * factor, then a
// restoring divider by the sample rate (one quotient bit per step), then a
// step to form the length; in_i.ready stays low meanwhile. Reset clears the
// window, the payload count and the output valid flag. A stalled output holds
// the result and blocks the next byte only when the output register is full.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_splitter (
  input logic        clk_i,
  input logic        rst_ni,
  mafs_in_if.sink    in_i,
  mafs_out_if.source out_o
);
  import mafs_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);
  localparam logic [CntW-1:0] CntLast = CntW'(NumW - 1);

  state_e            state_q, state_d;
  logic [31:0]       window_q, window_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [HzW-1:0]    rem_q, rem_d;
  logic [HzW-1:0]    hz_q, hz_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              out_free, take_ok, accept, out_load;

  // hunt-side decode of the shifted window
  logic [31:0]       win_sh;
  logic [1:0]        ver_s, lay_s;
  logic [KbpsW-1:0]  kbps_s;
  logic [HzW-1:0]    hz_s;
  logic              hdr_ok;

  // decode of the held header
  logic [1:0]        ver_h, lay_h;
  logic [KbpsW-1:0]  kbps_h;
  logic [FactW-1:0]  factor;
  logic [KbpsW+FactW-1:0] prod;

  // divider step
  logic [HzW:0]      rem_sh, rem_diff;
  logic              rem_ge;

  logic [LenW-1:0]   len_sum, len;

  assign out_free = !out_valid_q || out_o.ready;
  assign take_ok  = (state_q == ST_HUNT || state_q == ST_PAYLOAD) && out_free;
  assign accept   = in_i.valid && take_ok;
  assign in_i.ready = take_ok;

  assign win_sh = {window_q[23:0], in_i.data_byte};
  assign ver_s  = decode_version(win_sh[20:19]);
  assign lay_s  = decode_layer(win_sh[18:17]);
  assign kbps_s = decode_kbps(ver_s, lay_s, win_sh[15:12]);
  assign hz_s   = decode_rate(ver_s, win_sh[11:10]);
  assign hdr_ok = (win_sh[31:21] == '1) && (ver_s != VER_NONE) && (lay_s != LAYER_NONE)
                  && (kbps_s != '0) && (hz_s != '0);

  assign ver_h  = decode_version(window_q[20:19]);
  assign lay_h  = decode_layer(window_q[18:17]);
  assign kbps_h = decode_kbps(ver_h, lay_h, window_q[15:12]);
  assign factor = (lay_h == LAYER_1) ? FACTOR_L1 : FACTOR_L23;
  assign prod   = kbps_h * factor;

  assign rem_sh   = {rem_q, num_q[NumW-1]};
  assign rem_diff = rem_sh - {1'b0, hz_q};
  assign rem_ge   = rem_sh >= {1'b0, hz_q};

  assign len_sum = num_q[LenW-1:0] + LenW'(window_q[9]);
  assign len     = (lay_h == LAYER_1) ? {len_sum[LenW-3:0], 2'b00} : len_sum;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_HUNT: begin
        if (accept && hdr_ok) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CntLast) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (out_free) begin
          state_d = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (accept && left_q <= LenW'(1)) begin
          state_d = ST_HUNT;
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  // datapath and output register
  always_comb begin
    window_d = window_q;
    left_d   = left_q;
    num_d    = num_q;
    rem_d    = rem_q;
    hz_d     = hz_q;
    cnt_d    = cnt_q;
    out_d    = out_q;
    out_load = 1'b0;
    case (state_q)
      ST_HUNT: begin
        if (accept) begin
          window_d = win_sh;
          if (!hdr_ok) begin
            out_load       = 1'b1;
            out_d          = '0;
            out_d.out_byte = in_i.data_byte;
            out_d.status   = STATUS_SKIP;
          end
        end
      end
      ST_MUL: begin
        num_d = prod[NumW-1:0];
        rem_d = '0;
        hz_d  = decode_rate(ver_h, window_q[11:10]);
        cnt_d = '0;
      end
      ST_DIV: begin
        num_d = {num_q[NumW-2:0], rem_ge};
        rem_d = rem_ge ? rem_diff[HzW-1:0] : rem_sh[HzW-1:0];
        cnt_d = cnt_q + CntW'(1);
      end
      ST_LEN: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_d.out_byte       = window_q[7:0];
          out_d.status         = STATUS_HEADER;
          out_d.version_code   = ver_h;
          out_d.layer_number   = lay_h;
          out_d.protection_bit = window_q[16];
          out_d.bitrate_kbps   = kbps_h;
          out_d.sample_rate_hz = hz_q;
          out_d.padding_bit    = window_q[9];
          out_d.channel_mode   = window_q[7:6];
          out_d.frame_bytes    = len;
          out_d.last_of_frame  = 1'b0;
          left_d = (len > HDR_BYTES) ? len - HDR_BYTES : '0;
        end
      end
      ST_PAYLOAD: begin
        if (accept) begin
          out_load       = 1'b1;
          out_d          = '0;
          out_d.out_byte = in_i.data_byte;
          out_d.status   = STATUS_PAYLOAD;
          if (left_q <= LenW'(1)) begin
            // frame done: drop the window and hunt again
            out_d.last_of_frame = 1'b1;
            left_d   = '0;
            window_d = '0;
          end else begin
            left_d = left_q - LenW'(1);
          end
        end
      end
      default: ;
    endcase
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      window_q    <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    hz_q  <= hz_d;
    out_q <= out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_q.out_byte;
  assign out_o.status         = out_q.status;
  assign out_o.version_code   = out_q.version_code;
  assign out_o.layer_number   = out_q.layer_number;
  assign out_o.protection_bit = out_q.protection_bit;
  assign out_o.bitrate_kbps   = out_q.bitrate_kbps;
  assign out_o.sample_rate_hz = out_q.sample_rate_hz;
  assign out_o.padding_bit    = out_q.padding_bit;
  assign out_o.channel_mode   = out_q.channel_mode;
  assign out_o.frame_bytes    = out_q.frame_bytes;
  assign out_o.last_of_frame  = out_q.last_of_frame;

  // a header byte starts the length computation and produces no item yet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_HUNT && hdr_ok) |=> (state_q == ST_MUL && !out_load))
    else $error("header byte did not start length computation");

  // the divider hands over to the length step after its last quotient bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntLast) |=> (state_q == ST_LEN))
    else $error("divider did not finish after its last step");

  // while passing payload the window still holds the sync pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAYLOAD) |-> (window_q[31:21] == '1))
    else $error("payload without a held header");

  // the last payload byte clears the window and returns to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_PAYLOAD && left_q <= LenW'(1))
      |=> (state_q == ST_HUNT && window_q == '0 && out_q.last_of_frame))
    else $error("frame end not handled");

endmodule
